/* hw/rtl/bbf_pkg.sv */
package bbf_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    // Width of the capacity register, the pop count and the fill level.
    localparam int CNT_W  = 13;

    localparam logic [CNT_W-1:0] CAP_RESET = 13'd4096;

    // Per-transaction flags passed from the controller to the top level.
    typedef struct packed {
        logic accepted;
        logic head_valid;
        logic closed;
        logic finished;
    } status_t;

endpackage

/* hw/rtl/bounded_byte_fifo_top.sv */
// Channel   Signals                                        Handshake
// -------   --------------------------------------------   ----------------------
// command   kind, data_byte, pop_count                     start high, busy low
// result    accepted, head_byte, head_valid, buffered,     done, one cycle wide
//           space_left, pushed_total, popped_total,
//           closed, finished
// config    cfg_wr_data (capacity in bytes)                cfg_wr_en
//
// One transaction is taken every cycle while busy is low; its result appears on done
// in the next cycle, since the byte memory read is registered.
// Reset is asynchronous and active low; busy is set by reset and cleared by the next clock.
// The receiver cannot stall, so busy never rises once the block is running.
module bounded_byte_fifo_top
    import bbf_pkg::*;
#(
    parameter int DEPTH      = 4096,
    parameter int COUNT_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CNT_W-1:0]      cfg_wr_data,
    input  logic                  start,
    output logic                  busy,
    input  logic [KIND_W-1:0]     kind,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic [CNT_W-1:0]      pop_count,
    output logic                  done,
    output logic                  accepted,
    output logic [BYTE_W-1:0]     head_byte,
    output logic                  head_valid,
    output logic [CNT_W-1:0]      buffered,
    output logic [CNT_W-1:0]      space_left,
    output logic [COUNT_BITS-1:0] pushed_total,
    output logic [COUNT_BITS-1:0] popped_total,
    output logic                  closed,
    output logic                  finished
);

    localparam int PTR_W = $clog2(DEPTH);

    logic              busy_reg;
    logic              done_reg;
    logic              item_go;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [PTR_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_data;
    status_t           status;

    assign item_go = start && !busy_reg;

    // Busy is set by reset and cleared by the first clock; done marks each result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            done_reg <= item_go;
        end
    end

    bbf_ctrl #(
        .DEPTH      (DEPTH),
        .PTR_W      (PTR_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_go      (item_go),
        .kind         (kind),
        .data_byte    (data_byte),
        .pop_count    (pop_count),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .buffered     (buffered),
        .space_left   (space_left),
        .pushed_total (pushed_total),
        .popped_total (popped_total),
        .status       (status)
    );

    bbf_store #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (item_go),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result outputs; the head byte reads as zero when the stream is empty.
    assign busy       = busy_reg;
    assign done       = done_reg;
    assign accepted   = status.accepted;
    assign head_byte  = status.head_valid ? rd_data : '0;
    assign head_valid = status.head_valid;
    assign closed     = status.closed;
    assign finished   = status.finished;

`ifndef SYNTHESIS
    // Every accepted transaction yields exactly one result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("missing result after accepted transaction");

    // A result is only produced for an accepted transaction.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without transaction");

    // The pushed total advances exactly when a byte is stored.
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(rst_n)) |->
            (pushed_total == ($past(pushed_total) + COUNT_BITS'(accepted))))
        else $error("pushed total out of step with accepted bytes");

    // A stored byte leaves the stream non-empty.
    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && accepted) |-> (head_valid && (buffered != '0)))
        else $error("stream empty after an accepted push");
`endif

endmodule

/* hw/rtl/bbf_store.sv */
module bbf_store
    import bbf_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int PTR_W = 12
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [PTR_W-1:0]  wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [PTR_W-1:0]  rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Byte storage write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; a write to the same entry in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/bbf_ctrl.sv */
module bbf_ctrl
    import bbf_pkg::*;
#(
    parameter int DEPTH      = 4096,
    parameter int PTR_W      = 12,
    parameter int COUNT_BITS = 48
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CNT_W-1:0]      cfg_wr_data,
    input  logic                  item_go,
    input  logic [KIND_W-1:0]     kind,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic [CNT_W-1:0]      pop_count,
    output logic                  wr_en,
    output logic [PTR_W-1:0]      wr_addr,
    output logic [BYTE_W-1:0]     wr_data,
    output logic [PTR_W-1:0]      rd_addr,
    output logic [CNT_W-1:0]      buffered,
    output logic [CNT_W-1:0]      space_left,
    output logic [COUNT_BITS-1:0] pushed_total,
    output logic [COUNT_BITS-1:0] popped_total,
    output status_t               status
);

    localparam int DW = $clog2(DEPTH + 1);
    localparam int CW = (DW > CNT_W) ? DW : CNT_W;
    localparam int SW = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

    logic [CNT_W-1:0]      cap_reg;
    logic [PTR_W-1:0]      rptr_reg,   rptr_next;
    logic [PTR_W-1:0]      wptr_reg,   wptr_next;
    logic [CNT_W-1:0]      held_reg,   held_next;
    logic [COUNT_BITS-1:0] pushed_reg, pushed_next;
    logic [COUNT_BITS-1:0] popped_reg, popped_next;
    logic                  closed_reg, closed_next;
    logic                  acc_reg,    acc_next;

    logic [CNT_W-1:0] eff_cap;
    logic [CNT_W-1:0] pop_n;
    logic [SW-1:0]    rsum;
    logic             push_ok;

    // Capacity register; the user must write it only while the block is idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Effective capacity saturates at the storage depth.
    assign eff_cap = (CW'(cap_reg) > CW'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;
    assign push_ok = (kind == KIND_PUSH) && (held_reg < eff_cap);
    assign pop_n   = (pop_count < held_reg) ? pop_count : held_reg;

    // Read pointer advance with a single wrap at the depth.
    always_comb
    begin
        rsum = SW'(rptr_reg) + SW'(pop_n);
        if (rsum >= SW'(DEPTH))
        begin
            rsum = rsum - SW'(DEPTH);
        end
    end

    // Next-state logic for one transaction.
    always_comb
    begin
        rptr_next   = rptr_reg;
        wptr_next   = wptr_reg;
        held_next   = held_reg;
        pushed_next = pushed_reg;
        popped_next = popped_reg;
        closed_next = closed_reg;
        acc_next    = 1'b0;
        case (kind)
            KIND_PUSH:
            begin
                if (push_ok)
                begin
                    wptr_next   = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                    held_next   = held_reg + 1'b1;
                    pushed_next = pushed_reg + 1'b1;
                    acc_next    = 1'b1;
                end
            end
            KIND_POP:
            begin
                rptr_next   = rsum[PTR_W-1:0];
                held_next   = held_reg - pop_n;
                popped_next = popped_reg + COUNT_BITS'(pop_n);
            end
            KIND_CLOSE:
            begin
                closed_next = 1'b1;
            end
            default:
            begin
                closed_next = closed_reg;
            end
        endcase
    end

    // Stream state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg   <= '0;
            wptr_reg   <= '0;
            held_reg   <= '0;
            pushed_reg <= '0;
            popped_reg <= '0;
            closed_reg <= 1'b0;
            acc_reg    <= 1'b0;
        end
        else if (item_go)
        begin
            rptr_reg   <= rptr_next;
            wptr_reg   <= wptr_next;
            held_reg   <= held_next;
            pushed_reg <= pushed_next;
            popped_reg <= popped_next;
            closed_reg <= closed_next;
            acc_reg    <= acc_next;
        end
    end

    // Memory requests: write the pushed byte, read the new head.
    assign wr_en   = item_go && push_ok;
    assign wr_addr = wptr_reg;
    assign wr_data = data_byte;
    assign rd_addr = rptr_next;

    // Status of the last transaction.
    assign buffered          = held_reg;
    assign space_left        = (held_reg < eff_cap) ? eff_cap - held_reg : '0;
    assign pushed_total      = pushed_reg;
    assign popped_total      = popped_reg;
    assign status.accepted   = acc_reg;
    assign status.head_valid = (held_reg != '0);
    assign status.closed     = closed_reg;
    assign status.finished   = closed_reg && (held_reg == '0);

endmodule
